FILE: design/art_pkg.sv
// Shared widths, constants and the stage record of the acceleration run timer.
// No dependencies; the channel interfaces and all timer modules import it.
`default_nettype none

package art_pkg;

   localparam int unsigned SPEED_W    = 8;
   localparam int unsigned STAMP_W    = 32;
   localparam int unsigned DIST_W     = 32;
   localparam int unsigned TENTHS_W   = 16;
   localparam int unsigned STAGE_W    = 2;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned SLOT_COUNT = 4;

   localparam logic [STAGE_W-1:0] STAGE_REST    = 2'd0;
   localparam logic [STAGE_W-1:0] STAGE_WAIT    = 2'd1;
   localparam logic [STAGE_W-1:0] STAGE_MEASURE = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_MARK  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_MARK = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_THIRD_MARK  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIST_GOAL   = 2'd3;

   // Elapsed time below TENTHS_SAT_LIMIT divides exactly by the reciprocal below;
   // at or above it the tenths count saturates.
   localparam int unsigned DIFF_W = 23;
   localparam int unsigned RECIP_W = 24;
   localparam int unsigned RECIP_SHIFT = 30;
   localparam logic [RECIP_W-1:0] TENTHS_RECIP = 24'd10737419;
   localparam logic [STAMP_W-1:0] TENTHS_STEP = 32'd100;
   localparam logic [STAMP_W-1:0] TENTHS_SAT_LIMIT = 32'd6553600;

   // Work for one sample after the stage update, before the tenths scaling.
   typedef struct packed {
      logic [STAGE_W-1:0]    stage;
      logic [DIST_W-1:0]     distance;
      logic [DIFF_W-1:0]     diff;
      logic                  sat;
      logic [SLOT_COUNT-1:0] mask;
      logic                  clear;
   } art_step_type;

endpackage

`default_nettype wire

FILE: design/art_chan_if.sv
// Valid/ready channel interfaces for the timer's sample input and result output.
// Depends on art_pkg for the field widths.
`default_nettype none

interface art_req_if;
   import art_pkg::*;
   logic               valid;
   logic               ready;
   logic [SPEED_W-1:0] speed_mph;
   logic [STAMP_W-1:0] now_ms;
   modport source (output valid, speed_mph, now_ms, input ready);
   modport sink   (input valid, speed_mph, now_ms, output ready);
endinterface

interface art_rsp_if;
   import art_pkg::*;
   logic                valid;
   logic                ready;
   logic [STAGE_W-1:0]  run_stage;
   logic [TENTHS_W-1:0] split_one_tenths;
   logic [TENTHS_W-1:0] split_two_tenths;
   logic [TENTHS_W-1:0] split_three_tenths;
   logic [TENTHS_W-1:0] goal_time_tenths;
   logic [DIST_W-1:0]   run_distance;
   logic                split_recorded;
   modport source (output valid, run_stage, split_one_tenths, split_two_tenths,
                   split_three_tenths, goal_time_tenths, run_distance, split_recorded,
                   input ready);
   modport sink   (input valid, run_stage, split_one_tenths, split_two_tenths,
                   split_three_tenths, goal_time_tenths, run_distance, split_recorded,
                   output ready);
endinterface

`default_nettype wire

FILE: design/art_tenths.sv
// Converts elapsed milliseconds to saturated tenths of a second.
// Divide by 100 done as a reciprocal multiply; depends on art_pkg.
`default_nettype none

module art_tenths (
   input  logic [art_pkg::DIFF_W-1:0]   diff,
   input  logic                         sat,
   output logic [art_pkg::TENTHS_W-1:0] tenths
);
   import art_pkg::*;

   localparam int unsigned PROD_W = DIFF_W + RECIP_W;

   logic [PROD_W-1:0] scaled;

   assign scaled = PROD_W'(diff) * PROD_W'(TENTHS_RECIP);
   assign tenths = sat ? {TENTHS_W{1'b1}} : scaled[RECIP_SHIFT +: TENTHS_W];

endmodule

`default_nettype wire

FILE: design/acceleration_run_timer_core.sv
// Standing-start acceleration run timer: stage control, split latching, distance.
// Depends on art_pkg, art_req_if/art_rsp_if and art_tenths.
//
//   channel   | direction | handshake            | payload
//   ----------+-----------+----------------------+----------------------------------
//   req_chan  | in        | valid/ready          | speed_mph, now_ms
//   rsp_chan  | out       | valid/ready          | stage, four split times, distance, recorded flag
//   csr_*     | in        | csr_write_enable     | csr_index, csr_write_data
//
// One sample is taken per cycle while req ready is high; its result then passes the stages below.
// Stages: capture and interval, speed*interval multiply, stage/distance update,
// tenths reciprocal multiply into the output register.
// A held rsp stalls only the full stages; bubbles still fill, so up to four
// transactions wait before req ready drops. req ready is low during reset.
// Synchronous reset restores the register defaults and idle state; no clearing pass.
`default_nettype none

module acceleration_run_timer_core (
   input  logic                           clock,
   input  logic                           reset,
   art_req_if.sink                        req_chan,
   art_rsp_if.source                      rsp_chan,
   input  logic                           csr_write_enable,
   input  logic [art_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [art_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import art_pkg::*;

   localparam int unsigned PROD_W = SPEED_W + STAMP_W;
   localparam int unsigned SUM_W  = PROD_W + 1;

   localparam int unsigned SLOT_ONE   = 0;
   localparam int unsigned SLOT_TWO   = 1;
   localparam int unsigned SLOT_THREE = 2;
   localparam int unsigned SLOT_GOAL  = 3;

   // configuration
   logic [SPEED_W-1:0] mark1_ff, mark2_ff, mark3_ff;
   logic [DIST_W-1:0]  goal_ff;

   // pipeline control
   logic p1_v_ff, p2_v_ff, p3_v_ff, out_v_ff;
   logic en1, en2, en3, en_out, accept, fire_b, fire_o;

   // stage 1: captured sample
   logic [STAMP_W-1:0] prev_ff;
   logic [SPEED_W-1:0] p1_speed_ff;
   logic [STAMP_W-1:0] p1_now_ff;
   logic [STAMP_W-1:0] p1_interval_ff;

   // stage 2: sample with distance increment
   logic [SPEED_W-1:0] p2_speed_ff;
   logic [STAMP_W-1:0] p2_now_ff;
   logic [PROD_W-1:0]  p2_product_ff;

   // run state
   logic [STAGE_W-1:0] stage_ff, stage_in;
   logic [STAMP_W-1:0] start_ff, start_in;
   logic [DIST_W-1:0]  dist_ff, dist_in;
   logic [2:0]         rec_ff, rec_in;

   logic [SUM_W-1:0]   sum_wide;
   logic [DIST_W-1:0]  dist_sat;
   logic [STAMP_W-1:0] diff_full;
   logic               zero_tenths;
   logic [SLOT_COUNT-1:0] mask_in;
   logic               clear_in;

   // stage 3 record
   art_step_type step_in, p3_ff;

   // output stage
   logic [TENTHS_W-1:0] tenths;
   logic [TENTHS_W-1:0] split_ff [SLOT_COUNT];
   logic [TENTHS_W-1:0] split_in [SLOT_COUNT];
   logic [STAGE_W-1:0]  rsp_stage_ff;
   logic [TENTHS_W-1:0] rsp_split_ff [SLOT_COUNT];
   logic [DIST_W-1:0]   rsp_dist_ff;
   logic                rsp_rec_ff;

   assign en_out = !out_v_ff || rsp_chan.ready;
   assign en3    = !p3_v_ff || en_out;
   assign en2    = !p2_v_ff || en3;
   assign en1    = !p1_v_ff || en2;
   assign accept = req_chan.valid && req_chan.ready;
   assign fire_b = p2_v_ff && en3;
   assign fire_o = p3_v_ff && en_out;

   assign req_chan.ready = en1 && !reset;

   // ---------------- stage update logic ----------------
   assign sum_wide  = SUM_W'(dist_ff) + SUM_W'(p2_product_ff);
   assign dist_sat  = (|sum_wide[SUM_W-1:DIST_W]) ? {DIST_W{1'b1}} : sum_wide[DIST_W-1:0];
   assign diff_full = p2_now_ff - start_ff;
   assign zero_tenths = diff_full < TENTHS_STEP;

   always_comb begin
      stage_in = stage_ff;
      start_in = start_ff;
      dist_in  = dist_sat;
      rec_in   = rec_ff;
      mask_in  = '0;
      clear_in = 1'b0;
      case (stage_ff)
         STAGE_WAIT: begin
            if (p2_speed_ff == '0) begin
               // start of a run: clear distance and all times
               stage_in = STAGE_MEASURE;
               start_in = p2_now_ff;
               dist_in  = '0;
               rec_in   = '0;
               clear_in = 1'b1;
            end
         end
         STAGE_MEASURE: begin
            // a split latched with zero tenths stays unrecorded
            if (!rec_ff[SLOT_THREE] && p2_speed_ff >= mark3_ff) begin
               mask_in[SLOT_THREE] = 1'b1;
               rec_in[SLOT_THREE]  = !zero_tenths;
            end else if (!rec_ff[SLOT_TWO] && p2_speed_ff >= mark2_ff) begin
               mask_in[SLOT_TWO] = 1'b1;
               rec_in[SLOT_TWO]  = !zero_tenths;
            end else if (!rec_ff[SLOT_ONE] && p2_speed_ff >= mark1_ff) begin
               mask_in[SLOT_ONE] = 1'b1;
               rec_in[SLOT_ONE]  = !zero_tenths;
            end else if (p2_speed_ff == '0) begin
               stage_in = STAGE_REST;
            end
            if (stage_in == STAGE_MEASURE && dist_sat != '0 && dist_sat >= goal_ff) begin
               mask_in[SLOT_GOAL] = 1'b1;
               stage_in = STAGE_REST;
            end
         end
         default: begin
            if (p2_speed_ff == '0) begin
               stage_in = STAGE_WAIT;
            end
         end
      endcase
   end

   always_comb begin
      step_in.stage    = stage_in;
      step_in.distance = dist_in;
      step_in.diff     = diff_full[DIFF_W-1:0];
      step_in.sat      = diff_full >= TENTHS_SAT_LIMIT;
      step_in.mask     = mask_in;
      step_in.clear    = clear_in;
   end

   // ---------------- output stage ----------------
   art_tenths u_tenths (
      .diff   (p3_ff.diff),
      .sat    (p3_ff.sat),
      .tenths (tenths)
   );

   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (p3_ff.clear) begin
            split_in[i] = '0;
         end else if (p3_ff.mask[i]) begin
            split_in[i] = tenths;
         end else begin
            split_in[i] = split_ff[i];
         end
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff  <= 1'b0;
         p2_v_ff  <= 1'b0;
         p3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         prev_ff  <= '0;
         stage_ff <= STAGE_REST;
         start_ff <= '0;
         dist_ff  <= '0;
         rec_ff   <= '0;
         mark1_ff <= 8'd60;
         mark2_ff <= 8'd100;
         mark3_ff <= 8'd120;
         goal_ff  <= 32'd900000;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            split_ff[i] <= '0;
         end
      end else begin
         if (en1) p1_v_ff <= req_chan.valid;
         if (en2) p2_v_ff <= p1_v_ff;
         if (en3) p3_v_ff <= p2_v_ff;
         if (en_out) out_v_ff <= p3_v_ff;
         if (accept) prev_ff <= req_chan.now_ms;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_FIRST_MARK:  mark1_ff <= csr_write_data[SPEED_W-1:0];
               CSR_SECOND_MARK: mark2_ff <= csr_write_data[SPEED_W-1:0];
               CSR_THIRD_MARK:  mark3_ff <= csr_write_data[SPEED_W-1:0];
               CSR_DIST_GOAL:   goal_ff  <= csr_write_data[DIST_W-1:0];
               default: ;
            endcase
         end
         if (fire_b) begin
            stage_ff <= stage_in;
            start_ff <= start_in;
            dist_ff  <= dist_in;
            rec_ff   <= rec_in;
         end
         if (fire_o) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               split_ff[i] <= split_in[i];
            end
         end
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         p1_speed_ff    <= req_chan.speed_mph;
         p1_now_ff      <= req_chan.now_ms;
         p1_interval_ff <= req_chan.now_ms - prev_ff;
      end
      if (en2 && p1_v_ff) begin
         p2_speed_ff   <= p1_speed_ff;
         p2_now_ff     <= p1_now_ff;
         p2_product_ff <= PROD_W'(p1_speed_ff) * PROD_W'(p1_interval_ff);
      end
      if (fire_b) begin
         p3_ff <= step_in;
      end
      if (fire_o) begin
         rsp_stage_ff <= p3_ff.stage;
         rsp_dist_ff  <= p3_ff.distance;
         rsp_rec_ff   <= |p3_ff.mask;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            rsp_split_ff[i] <= split_in[i];
         end
      end
   end

   assign rsp_chan.valid              = out_v_ff;
   assign rsp_chan.run_stage          = rsp_stage_ff;
   assign rsp_chan.split_one_tenths   = rsp_split_ff[SLOT_ONE];
   assign rsp_chan.split_two_tenths   = rsp_split_ff[SLOT_TWO];
   assign rsp_chan.split_three_tenths = rsp_split_ff[SLOT_THREE];
   assign rsp_chan.goal_time_tenths   = rsp_split_ff[SLOT_GOAL];
   assign rsp_chan.run_distance       = rsp_dist_ff;
   assign rsp_chan.split_recorded     = rsp_rec_ff;

   // ---------------- assertions ----------------
   a_one_split_per_sample: assert property (@(posedge clock) disable iff (reset)
      p3_v_ff |-> $onehot0(p3_ff.mask[SLOT_THREE:SLOT_ONE]))
      else $error("more than one split latched in one transaction");

   a_clear_without_latch: assert property (@(posedge clock) disable iff (reset)
      (p3_v_ff && p3_ff.clear) |-> (p3_ff.mask == '0 && p3_ff.distance == '0))
      else $error("run start latched a time or kept distance");

   a_wait_never_idles: assert property (@(posedge clock) disable iff (reset)
      (stage_ff == STAGE_WAIT) |=> (stage_ff != STAGE_REST))
      else $error("waiting stage dropped straight to idle");

   a_run_start_state: assert property (@(posedge clock) disable iff (reset)
      (fire_b && stage_ff == STAGE_WAIT && p2_speed_ff == '0)
      |=> (dist_ff == '0 && rec_ff == '0 && start_ff == $past(p2_now_ff)))
      else $error("run start did not reset distance, splits and start stamp");

endmodule

`default_nettype wire
